### hdl/tli_pkg.sv
// Shared constants, codes and types for the table linear interpolation block.
package tli_pkg;

  localparam int MAX_POINTS_DEF  = 64;
  localparam int VALUE_WIDTH_DEF = 32;

  localparam int IDX_W     = 6;
  localparam int X_W       = 32;
  localparam int CNT_W     = 7;
  localparam int STATUS_W  = 2;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;
  localparam int S_TDATA_W = ((IDX_W + 2 * X_W + 7) / 8) * 8;

  localparam int DIVIDEND_W = 2 * X_W;
  localparam int DIVISOR_W  = X_W;
  localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic REG_POINT_COUNT = 1'b0;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FEW_PTS  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_ZERO_DX  = 2'd2;

  typedef struct packed {
    logic busy;
    logic done;
  } tli_div_stat_t;

endpackage

### hdl/tli_div.sv
// Bit-serial restoring divider: 64-bit dividend by 32-bit divisor, one bit per cycle.
module tli_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [tli_pkg::DIVIDEND_W-1:0] dividend,
  input  logic [tli_pkg::DIVISOR_W-1:0]  divisor,
  output tli_pkg::tli_div_stat_t         stat,
  output logic [tli_pkg::DIVIDEND_W-1:0] quotient,
  output logic [tli_pkg::DIVISOR_W-1:0]  remainder
);
  import tli_pkg::*;

  logic                  busy;
  logic                  done;
  logic [DIV_CNT_W-1:0]  cnt;
  logic [DIVIDEND_W-1:0] acc;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  dvs;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  ge;

  assign trial = {rem, acc[DIVIDEND_W-1]};
  assign ge    = trial >= {1'b0, dvs};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      if (start) begin
        busy <= 1'b1;
        done <= 1'b0;
        cnt  <= '0;
        acc  <= dividend;
        dvs  <= divisor;
        rem  <= '0;
      end else if (busy) begin
        acc <= {acc[DIVIDEND_W-2:0], ge};
        rem <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
        cnt <= cnt + DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(DIVIDEND_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          done <= 1'b0;
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = acc;
  assign remainder = rem;

endmodule

### hdl/table_linear_interpolation.sv
// Piecewise linear interpolation over a loaded breakpoint table, Q16.16.
// Load transaction: written in the accepting cycle; the input stays ready throughout.
// Query: result valid and input ready again in the same cycle, once the result is issued;
// it runs a binary search and the bit-serial divider. Error results skip the divider: too
// few points straight from idle, zero-width segment after the search. An untaken result
// holds the next query in its last state. Reset clears control and point_count only.
module table_linear_interpolation #(
  parameter int MAX_POINTS  = tli_pkg::MAX_POINTS_DEF,
  parameter int VALUE_WIDTH = tli_pkg::VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // APB-style configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tli_pkg::PADDR_W-1:0]   paddr,
  input  logic [tli_pkg::PDATA_W-1:0]   pwdata,
  output logic [tli_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  // input stream
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [tli_pkg::S_TDATA_W-1:0] s_tdata,  // point_index, abscissa, ordinate
  input  logic                          s_tuser,  // command
  // result stream
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [((VALUE_WIDTH + 3 + 7) / 8) * 8 - 1:0] m_tdata  // value, status, saturated
);
  import tli_pkg::*;

  localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int NW = $clog2(MAX_POINTS + 1);
  localparam int MW = ((VALUE_WIDTH + 3 + 7) / 8) * 8;
  localparam int RW = 66;
  localparam logic signed [RW-1:0] MAX_V = (RW'(1) <<< (VALUE_WIDTH - 1)) - RW'(1);
  localparam logic signed [RW-1:0] MIN_V = -MAX_V - RW'(1);
  localparam logic [VALUE_WIDTH-1:0] VMAX = {1'b0, {(VALUE_WIDTH - 1){1'b1}}};
  localparam logic [VALUE_WIDTH-1:0] VMIN = {1'b1, {(VALUE_WIDTH - 1){1'b0}}};
  localparam logic [DIVIDEND_W-1:0] QT_LIMIT = DIVIDEND_W'(1) << 62;

  typedef enum logic [3:0] {
    ST_IDLE, ST_X0, ST_XL, ST_X1, ST_X2, ST_SRCH, ST_CMP, ST_RLO, ST_RHI,
    ST_MUL, ST_DIV, ST_DIVW, ST_RND, ST_ADD, ST_SAT, ST_FIN
  } state_t;

  state_t state;

  // configuration
  logic [CNT_W-1:0] point_count;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_POINT_COUNT) ? PDATA_W'(point_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= '0;
    end else if (cfg_wr && paddr[2] == REG_POINT_COUNT) begin
      point_count <= pwdata[CNT_W-1:0];
    end
  end

  // input fields
  logic [IDX_W-1:0]     in_idx;
  logic [X_W-1:0]       in_x;
  logic [X_W-1:0]       in_y;
  logic                 s_fire;

  assign in_idx = s_tdata[IDX_W-1:0];
  assign in_x   = s_tdata[IDX_W +: X_W];
  assign in_y   = s_tdata[IDX_W + X_W +: X_W];
  assign s_tready = (state == ST_IDLE);
  assign s_fire = s_tvalid && s_tready;

  // points in use
  logic [NW-1:0] n;
  logic [NW-1:0] nm1_full;
  logic [NW-1:0] nm2_full;
  logic [IW-1:0] nm1;
  logic [IW-1:0] nm2;

  assign n = (32'(point_count) > 32'(MAX_POINTS)) ? NW'(MAX_POINTS) : NW'(point_count);
  assign nm1_full = n - NW'(1);
  assign nm2_full = n - NW'(2);
  assign nm1 = nm1_full[IW-1:0];
  assign nm2 = nm2_full[IW-1:0];

  // table RAM
  logic [X_W-1:0] mem_x [MAX_POINTS];
  logic [X_W-1:0] mem_y [MAX_POINTS];
  logic [IW-1:0]  rd_addr;
  logic [X_W-1:0] rd_x;
  logic [X_W-1:0] rd_y;
  logic           wr_en;

  assign wr_en = s_fire && s_tuser == CMD_LOAD && 32'(in_idx) < 32'(MAX_POINTS);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_x[IW'(in_idx)] <= in_x;
      mem_y[IW'(in_idx)] <= in_y;
    end
    rd_x <= mem_x[rd_addr];
    rd_y <= mem_y[rd_addr];
  end

  // datapath registers
  logic signed [X_W-1:0] q;
  logic signed [X_W-1:0] x_first;
  logic signed [X_W-1:0] x_lo;
  logic signed [X_W-1:0] y_lo;
  logic signed [X_W-1:0] y_hi;
  logic                  falling;
  logic [IW-1:0]         lo;
  logic [IW-1:0]         hi;
  logic [X_W-1:0]        mag_dy;
  logic [X_W-1:0]        mag_dq;
  logic [X_W-1:0]        mag_dx;
  logic                  neg;
  logic [DIVIDEND_W-1:0] prod;
  logic [DIVIDEND_W-1:0] qt;
  logic signed [RW-1:0]  r;
  logic [VALUE_WIDTH-1:0] res_value;
  logic [STATUS_W-1:0]   res_status;
  logic                  res_sat;

  // search and segment arithmetic
  logic signed [X_W-1:0] sx;
  logic signed [X_W-1:0] sy;
  logic [IW:0]           span;
  logic [IW-1:0]         mid;
  logic [IW-1:0]         lo_lim;
  logic                  go_up;
  logic                  x1_first;
  logic                  x2_last;
  logic signed [X_W:0]   dx;
  logic signed [X_W:0]   dy;
  logic signed [X_W:0]   dq;
  logic signed [X_W:0]   ndx;
  logic signed [X_W:0]   ndy;
  logic signed [X_W:0]   ndq;

  assign sx   = $signed(rd_x);
  assign sy   = $signed(rd_y);
  assign span = {1'b0, hi} - {1'b0, lo} + (IW + 1)'(1);
  assign mid  = lo + span[IW:1];
  assign lo_lim = (lo > nm2) ? nm2 : lo;
  assign go_up  = falling ? (sx >= q) : (sx <= q);
  assign x1_first = falling ? (q >= sx) : (q <= sx);
  assign x2_last  = falling ? (q <= sx) : (q >= sx);

  assign dx  = {sx[X_W-1], sx} - {x_lo[X_W-1], x_lo};
  assign dy  = {sy[X_W-1], sy} - {y_lo[X_W-1], y_lo};
  assign dq  = {q[X_W-1], q} - {sx[X_W-1], sx};
  assign ndx = -dx;
  assign ndy = -dy;
  assign ndq = -dq;

  always_comb begin
    unique case (state)
      ST_IDLE: rd_addr = '0;
      ST_X0:   rd_addr = nm1;
      ST_XL:   rd_addr = IW'(1);
      ST_X1:   rd_addr = x1_first ? '0 : nm2;
      ST_X2:   rd_addr = nm2;
      ST_SRCH: rd_addr = (lo < hi) ? mid : lo_lim;
      ST_RLO:  rd_addr = lo + IW'(1);
      default: rd_addr = lo;
    endcase
  end

  // divider
  tli_div_stat_t         div_stat;
  logic                  div_start;
  logic [DIVIDEND_W-1:0] div_q;
  logic [DIVISOR_W-1:0]  div_r;

  assign div_start = (state == ST_DIV);

  tli_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (prod),
    .divisor   (mag_dx),
    .stat      (div_stat),
    .quotient  (div_q),
    .remainder (div_r)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != ST_FIN) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_fire && s_tuser == CMD_QUERY) begin
            q <= $signed(in_x);
            if (n < NW'(2)) begin
              res_value  <= '0;
              res_status <= STATUS_FEW_PTS;
              res_sat    <= 1'b0;
              state      <= ST_FIN;
            end else begin
              state <= ST_X0;
            end
          end
        end
        ST_X0: begin
          x_first <= sx;
          state   <= ST_XL;
        end
        ST_XL: begin
          falling <= sx < x_first;
          state   <= ST_X1;
        end
        ST_X1: begin
          if (x1_first) begin
            lo    <= '0;
            state <= ST_RLO;
          end else begin
            state <= ST_X2;
          end
        end
        ST_X2: begin
          if (x2_last) begin
            lo    <= nm2;
            state <= ST_RLO;
          end else begin
            lo    <= '0;
            hi    <= nm1;
            state <= ST_SRCH;
          end
        end
        ST_SRCH: begin
          if (lo < hi) begin
            state <= ST_CMP;
          end else begin
            lo    <= lo_lim;
            state <= ST_RLO;
          end
        end
        ST_CMP: begin
          if (go_up) begin
            lo <= mid;
          end else begin
            hi <= mid - IW'(1);
          end
          state <= ST_SRCH;
        end
        ST_RLO: begin
          x_lo  <= sx;
          y_lo  <= sy;
          state <= ST_RHI;
        end
        ST_RHI: begin
          if (dx == '0) begin
            res_value  <= '0;
            res_status <= STATUS_ZERO_DX;
            res_sat    <= 1'b0;
            state      <= ST_FIN;
          end else begin
            y_hi   <= sy;
            mag_dx <= dx[X_W] ? ndx[X_W-1:0] : dx[X_W-1:0];
            mag_dy <= dy[X_W] ? ndy[X_W-1:0] : dy[X_W-1:0];
            mag_dq <= dq[X_W] ? ndq[X_W-1:0] : dq[X_W-1:0];
            neg    <= dy[X_W] ^ dq[X_W] ^ dx[X_W];
            state  <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod  <= DIVIDEND_W'(mag_dy) * DIVIDEND_W'(mag_dq);
          state <= ST_DIV;
        end
        ST_DIV: begin
          state <= ST_DIVW;
        end
        ST_DIVW: begin
          if (div_stat.done) begin
            state <= ST_RND;
          end
        end
        ST_RND: begin
          qt    <= ({div_r, 1'b0} >= {1'b0, mag_dx}) ? div_q + DIVIDEND_W'(1) : div_q;
          state <= ST_ADD;
        end
        ST_ADD: begin
          res_status <= STATUS_OK;
          if (qt > QT_LIMIT) begin
            res_value <= neg ? VMIN : VMAX;
            res_sat   <= 1'b1;
            state     <= ST_FIN;
          end else begin
            r     <= neg ? RW'(y_hi) - RW'(qt) : RW'(y_hi) + RW'(qt);
            state <= ST_SAT;
          end
        end
        ST_SAT: begin
          if (r > MAX_V) begin
            res_value <= VMAX;
            res_sat   <= 1'b1;
          end else if (r < MIN_V) begin
            res_value <= VMIN;
            res_sat   <= 1'b1;
          end else begin
            res_value <= r[VALUE_WIDTH-1:0];
            res_sat   <= 1'b0;
          end
          state <= ST_FIN;
        end
        ST_FIN: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= MW'({res_sat, res_status, res_value});
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[VALUE_WIDTH +: STATUS_W] != STATUS_OK |->
      m_tdata[VALUE_WIDTH-1:0] == '0 && !m_tdata[VALUE_WIDTH + STATUS_W])
    else $error("error status with nonzero value or saturation");

  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[VALUE_WIDTH + STATUS_W] |->
      m_tdata[VALUE_WIDTH-1:0] == VMAX || m_tdata[VALUE_WIDTH-1:0] == VMIN)
    else $error("saturated result not at a range limit");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    s_fire && s_tuser == CMD_QUERY |=> !s_tready)
    else $error("query accepted but block still ready");

  a_div_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_stat.busy |-> state == ST_DIVW)
    else $error("divider running outside its wait state");

endmodule

### tb/tb.sv
// Self-checking testbench for the table linear interpolation block.
`timescale 1ns / 1ps

module tb;
  import tli_pkg::*;

  localparam int NPTS        = MAX_POINTS_DEF;
  localparam int QUERY_WAIT  = 100;
  localparam int CYCLE_LIMIT = 600000;
  localparam int RAND_ITEMS  = 400;

  typedef struct {
    logic                cmd;
    logic [IDX_W-1:0]    idx;
    logic signed [31:0]  x;
    logic signed [31:0]  y;
  } point_cmd_t;

  typedef struct {
    logic signed [31:0]  value;
    logic [STATUS_W-1:0] status;
    logic                sat;
  } interp_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 psel    = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite  = 1'b0;
  logic [PADDR_W-1:0]   paddr   = '0;
  logic [PDATA_W-1:0]   pwdata  = '0;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata  = '0;  // point_index, abscissa, ordinate
  logic                 s_tuser  = 1'b0;  // command
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [39:0]          m_tdata;  // value, status, saturated

  table_linear_interpolation dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #5 clk = ~clk;

  // predictor state
  logic signed [31:0] tbl_x [NPTS];
  logic signed [31:0] tbl_y [NPTS];
  logic [CNT_W-1:0]   cfg_count = '0;

  point_cmd_t  pending_cmds [$];
  interp_res_t expected_interps [$];
  int          gen_x [$];
  bit          failed = 1'b0;
  int          results_seen = 0;
  int          cycle_count = 0;

  function automatic int find_segment(int n, longint q, bit falling);
    int lo, hi, mid;
    bit go_up;
    if (falling) begin
      if (q >= tbl_x[1]) return 0;
      if (q <= tbl_x[n-2]) return n - 2;
    end else begin
      if (q <= tbl_x[1]) return 0;
      if (q >= tbl_x[n-2]) return n - 2;
    end
    lo = 0;
    hi = n - 1;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      go_up = falling ? (tbl_x[mid] >= q) : (tbl_x[mid] <= q);
      if (go_up) lo = mid;
      else hi = mid - 1;
    end
    if (lo > n - 2) lo = n - 2;
    return lo;
  endfunction

  function automatic interp_res_t interpolate(longint q);
    interp_res_t r;
    int n, lo, hi;
    bit falling, neg;
    longint dx, dy, dq, v;
    logic [63:0] mdy, mdq, p, d, qt, rem;
    r.value = '0;
    r.status = STATUS_OK;
    r.sat = 1'b0;
    n = (cfg_count > NPTS) ? NPTS : int'(cfg_count);
    if (n < 2) begin
      r.status = STATUS_FEW_PTS;
      return r;
    end
    falling = tbl_x[n-1] < tbl_x[0];
    lo = find_segment(n, q, falling);
    hi = lo + 1;
    dx = longint'(tbl_x[hi]) - longint'(tbl_x[lo]);
    if (dx == 0) begin
      r.status = STATUS_ZERO_DX;
      return r;
    end
    dy = longint'(tbl_y[hi]) - longint'(tbl_y[lo]);
    dq = q - longint'(tbl_x[hi]);
    mdy = (dy < 0) ? -dy : dy;
    mdq = (dq < 0) ? -dq : dq;
    d = (dx < 0) ? -dx : dx;
    p = mdy * mdq;
    qt = p / d;
    rem = p % d;
    if (rem >= d - rem) qt = qt + 1;
    neg = ((dy < 0) != (dq < 0)) != (dx < 0);
    if (qt > 64'h4000_0000_0000_0000) begin
      v = neg ? -64'sd2147483648 : 64'sd2147483647;
      r.sat = 1'b1;
    end else begin
      v = neg ? longint'(tbl_y[hi]) - longint'(qt) : longint'(tbl_y[hi]) + longint'(qt);
      if (v > 64'sd2147483647) begin
        v = 64'sd2147483647;
        r.sat = 1'b1;
      end else if (v < -64'sd2147483648) begin
        v = -64'sd2147483648;
        r.sat = 1'b1;
      end
    end
    r.value = v[31:0];
    return r;
  endfunction

  // sender: bursts with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin : sender
    point_cmd_t cur;
    if (rst) begin
      s_tvalid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else if (!s_tvalid || s_tready) begin
      if (gap_left > 0 || pending_cmds.size() == 0) begin
        if (gap_left > 0) gap_left--;
        s_tvalid <= 1'b0;
      end else begin
        cur = pending_cmds.pop_front();
        s_tvalid <= 1'b1;
        s_tuser <= cur.cmd;
        s_tdata <= S_TDATA_W'({cur.y, cur.x, cur.idx});
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
        end
      end
    end
  end

  // receiver: own stall pattern plus two long hold-offs
  int rx_mode = 0;
  int mode_left = 0;
  int hold_left = 0;
  int holds_done = 0;
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (hold_left == 0 && holds_done < 2 &&
          results_seen >= ((holds_done == 0) ? 30 : 150)) begin
        hold_left = 400;
        holds_done++;
      end
      if (mode_left == 0) begin
        rx_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(16, 128);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        case (rx_mode)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          default: m_tready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  // scoreboard: results first, then accepted commands
  always @(posedge clk) begin : scoreboard
    interp_res_t got, want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got.value = m_tdata[31:0];
        got.status = m_tdata[33:32];
        got.sat = m_tdata[34];
        if (expected_interps.size() == 0) begin
          $display("%0t: unexpected result value %0d status %0d saturated %0b",
                   $time, got.value, got.status, got.sat);
          failed = 1'b1;
        end else begin
          want = expected_interps.pop_front();
          if (got.value !== want.value || got.status !== want.status ||
              got.sat !== want.sat) begin
            $display("%0t: mismatch expected value %0d status %0d saturated %0b, got %0d %0d %0b",
                     $time, want.value, want.status, want.sat,
                     got.value, got.status, got.sat);
            failed = 1'b1;
          end
        end
        results_seen++;
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser == CMD_LOAD) begin
          tbl_x[s_tdata[5:0]] = s_tdata[37:6];
          tbl_y[s_tdata[5:0]] = s_tdata[69:38];
        end else begin
          expected_interps.push_back(interpolate(longint'($signed(s_tdata[37:6]))));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout", $time);
      $display("Verification failed");
      $finish;
    end
  end

  task automatic push_load(int idx, int x, int y);
    point_cmd_t c;
    c.cmd = CMD_LOAD;
    c.idx = idx[IDX_W-1:0];
    c.x = x;
    c.y = y;
    pending_cmds.push_back(c);
  endtask

  task automatic push_query(int q);
    point_cmd_t c;
    c.cmd = CMD_QUERY;
    c.idx = IDX_W'($urandom_range(0, NPTS - 1));
    c.x = q;
    c.y = $urandom;
    pending_cmds.push_back(c);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (pending_cmds.size() != 0 || s_tvalid || expected_interps.size() != 0)
      @(negedge clk);
    repeat (QUERY_WAIT) @(negedge clk);
  endtask

  task automatic set_count(int cnt);
    wait_idle();
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'(4 * int'(REG_POINT_COUNT));
    pwdata <= PDATA_W'(cnt);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cfg_count = cnt[CNT_W-1:0];
    @(negedge clk);
  endtask

  // sorted table, rising or falling, with occasional repeated abscissas
  task automatic load_table(int n);
    int ys [$];
    bit wide, fall;
    int v;
    wide = ($urandom_range(0, 3) == 0);
    fall = 1'($urandom_range(0, 1));
    gen_x.delete();
    for (int i = 0; i < n; i++) begin
      if (i > 0 && $urandom_range(0, 9) == 0) v = gen_x[i-1];
      else if (wide) v = $urandom;
      else if (i == 0) v = int'($urandom_range(0, 2097152)) - 1048576;
      else v = gen_x[i-1] + int'($urandom_range(1, 262144));
      gen_x.push_back(v);
      ys.push_back(wide ? int'($urandom) : int'($urandom_range(0, 33554432)) - 16777216);
    end
    gen_x.sort();
    if (fall) gen_x.reverse();
    for (int i = 0; i < n; i++) push_load(i, gen_x[i], ys[i]);
  endtask

  task automatic random_query();
    int kind, n, i;
    longint lo_x, hi_x, q;
    kind = $urandom_range(0, 9);
    n = gen_x.size();
    if (n < 2 || kind >= 8) begin
      q = longint'(int'($urandom));
    end else if (kind < 4) begin
      i = $urandom_range(0, n - 2);
      lo_x = longint'((gen_x[i] < gen_x[i+1]) ? gen_x[i] : gen_x[i+1]);
      hi_x = longint'((gen_x[i] < gen_x[i+1]) ? gen_x[i+1] : gen_x[i]);
      q = lo_x + (longint'($urandom) % (hi_x - lo_x + 1));
    end else if (kind < 6) begin
      q = longint'(gen_x[$urandom_range(0, n - 1)]);
    end else begin
      q = (kind == 6) ? longint'(gen_x[0]) - $urandom_range(1, 4194304)
                      : longint'(gen_x[n-1]) + $urandom_range(1, 4194304);
      if (q > 64'sd2147483647) q = 64'sd2147483647;
      if (q < -64'sd2147483648) q = -64'sd2147483648;
    end
    push_query(int'(q));
  endtask

  initial begin
    int rand_items, phase, cnt, nq;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: too few points
    set_count(0);
    push_query(32'h7fff_ffff);
    push_load(0, 32'h8000_0000, 32'h7fff_ffff);
    set_count(1);
    push_query(0);

    // directed: full-range segment, both ends and middle
    set_count(2);
    push_load(1, 32'h7fff_ffff, 32'h8000_0000);
    push_query(32'h8000_0000);
    push_query(32'h7fff_ffff);
    push_query(0);

    // directed: steep segment, clipping on both sides
    push_load(0, 0, 0);
    push_load(1, 1, 32'h7fff_ffff);
    push_query(32'h7fff_ffff);
    push_query(32'h8000_0000);
    push_load(0, 0, 32'h8000_0000);
    push_query(32'h7fff_ffff);

    // directed: zero-width segment
    push_load(0, 5, 7);
    push_load(1, 5, 9);
    push_query(5);

    // directed: falling table, rounding tie, exact breakpoint, both sides
    set_count(3);
    push_load(0, 2, 0);
    push_load(1, 0, 1);
    push_load(2, -2, -5);
    push_query(1);
    push_query(0);
    push_query(100);
    push_query(-100);

    // random phases
    rand_items = 0;
    phase = 0;
    while (rand_items < RAND_ITEMS) begin
      case (phase % 7)
        0: cnt = NPTS;
        1: cnt = $urandom_range(2, 6);
        2: cnt = 127;
        3: cnt = $urandom_range(2, 32);
        4: cnt = $urandom_range(0, 1);
        5: cnt = $urandom_range(65, 126);
        default: cnt = 2;
      endcase
      set_count(cnt);
      if (cnt >= 2) begin
        load_table((cnt > NPTS) ? NPTS : cnt);
        rand_items += (cnt > NPTS) ? NPTS : cnt;
      end
      nq = $urandom_range(10, 40);
      for (int k = 0; k < nq; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          push_load($urandom_range(0, NPTS - 1), $urandom, $urandom);
          rand_items++;
        end
        random_query();
        rand_items++;
      end
      phase++;
    end

    wait_idle();
    if (failed || expected_interps.size() != 0) begin
      $display("Verification failed");
    end else begin
      $display("Verification passed");
    end
    $finish;
  end

endmodule

### table_linear_interpolation.f
hdl/tli_pkg.sv
hdl/tli_div.sv
hdl/table_linear_interpolation.sv
tb/tb.sv
